/* rtl/lmac_pkg.sv */
// ----------------------------------------------------------------------------
// lmac_pkg
// Shared constants and types for the multi-limb multiply-accumulate block.
// ----------------------------------------------------------------------------
`default_nettype none

package lmac_pkg;

  localparam int MAX_LIMBS = 8;
  localparam int IDX_W     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int LIMB_W    = 64;
  localparam int PROD_W    = 2 * LIMB_W;
  localparam int ACC_W     = PROD_W + 8;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/lmac_cell.sv */
// ----------------------------------------------------------------------------
// lmac_cell
// One limb cell: holds a scalar limb, a multiplicand limb in a shift chain,
// and a work pair that streams toward the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module lmac_cell
  import lmac_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic              wr_scalar,
  input  wire logic [LIMB_W-1:0] scalar_in,
  input  wire logic [LIMB_W-1:0] mult_in,
  input  wire logic [LIMB_W-1:0] work_s_in,
  input  wire logic [LIMB_W-1:0] work_m_in,
  output logic      [LIMB_W-1:0] mult_out,
  output logic      [LIMB_W-1:0] work_s,
  output logic      [LIMB_W-1:0] work_m
);

  logic [LIMB_W-1:0] scalar;
  logic [LIMB_W-1:0] work_m_hold;

  assign mult_out = work_m_hold;

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      if (wr_scalar) begin
        scalar <= scalar_in;
        work_s <= scalar_in;
      end else begin
        work_s <= scalar;
      end
      work_m_hold <= mult_in;
      work_m      <= mult_in;
    end else if (ctl.shift) begin
      work_s <= work_s_in;
      work_m <= work_m_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/lmac_mul.sv */
// ----------------------------------------------------------------------------
// lmac_mul
// Two-stage 64x64 multiplier: four 32x32 partial products, then combine.
// ----------------------------------------------------------------------------
`default_nettype none

module lmac_mul
  import lmac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_v,
  input  wire logic [LIMB_W-1:0] a,
  input  wire logic [LIMB_W-1:0] b,
  output logic                   busy,
  output logic                   prod_v,
  output logic      [PROD_W-1:0] prod
);

  logic        v1;
  logic [63:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      v1     <= in_v;
      prod_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p00  <= 64'(a[31:0])  * 64'(b[31:0]);
    p01  <= 64'(a[31:0])  * 64'(b[63:32]);
    p10  <= 64'(a[63:32]) * 64'(b[31:0]);
    p11  <= 64'(a[63:32]) * 64'(b[63:32]);
    prod <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
  end

  assign busy = v1 | prod_v;

endmodule

`default_nettype wire

/* rtl/multi_limb_multiply_accumulate.sv */
// ----------------------------------------------------------------------------
// multi_limb_multiply_accumulate
// Streaming truncated base +/- scalar * multiplicand over 64-bit limbs.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready   | kind, base_limb, mult_limb,
//           |           |                       | scalar_limb, scalar_valid, last_in
//   out     | output    | out_valid / out_ready | result_limb, last_out
//
// Limb k issues k+1 products on the shared multiplier, then drains the multiplier
// and finishes into the output register; the next limb is taken only after the
// return to idle, so a limb is not taken before the last one is finished.
// A new limb is taken while the previous result waits in the output register.
// A stalled output holds the finish step until the register frees.
// Reset is synchronous and clears the run; stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_limb_multiply_accumulate
  import lmac_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              kind,
  input  wire logic [LIMB_W-1:0] base_limb,
  input  wire logic [LIMB_W-1:0] mult_limb,
  input  wire logic [LIMB_W-1:0] scalar_limb,
  input  wire logic              scalar_valid,
  input  wire logic              last_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [LIMB_W-1:0] result_limb,
  output logic                   last_out
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  limb_index;
  logic [IDX_W-1:0]  cnt;
  logic              op_latched;
  logic              carry_bit;
  logic [ACC_W-1:0]  acc;
  logic [LIMB_W-1:0] base;
  logic              fin;
  logic              accept, issue, finish;
  logic              mul_busy, prod_v;
  logic [PROD_W-1:0] prod;
  cell_ctl_t         ctl;

  logic [LIMB_W-1:0] mchain [MAX_LIMBS];
  logic [LIMB_W-1:0] ws     [MAX_LIMBS];
  logic [LIMB_W-1:0] wm     [MAX_LIMBS];

  assign accept = in_valid & in_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_RUN;
      ST_RUN:    if (cnt == limb_index) state_next = ST_DRAIN;
      ST_DRAIN:  if (!mul_busy) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE) && !rst;
    issue    = (state == ST_RUN);
    finish   = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  assign ctl.take  = accept;
  assign ctl.shift = issue;

  for (genvar i = 0; i < MAX_LIMBS; i++) begin : g_cell
    logic [LIMB_W-1:0] m_in, s_nb, m_nb;
    if (i == 0) begin : g_head
      assign m_in = mult_limb;
    end else begin : g_body
      assign m_in = mchain[i-1];
    end
    if (i == MAX_LIMBS - 1) begin : g_tail
      assign s_nb = '0;
      assign m_nb = '0;
    end else begin : g_mid
      assign s_nb = ws[i+1];
      assign m_nb = wm[i+1];
    end
    lmac_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wr_scalar (limb_index == IDX_W'(i)),
      .scalar_in (scalar_valid ? scalar_limb : '0),
      .mult_in   (m_in),
      .work_s_in (s_nb),
      .work_m_in (m_nb),
      .mult_out  (mchain[i]),
      .work_s    (ws[i]),
      .work_m    (wm[i])
    );
  end

  lmac_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .in_v   (issue),
    .a      (ws[0]),
    .b      (wm[0]),
    .busy   (mul_busy),
    .prod_v (prod_v),
    .prod   (prod)
  );

  logic [LIMB_W:0] sum_ext;
  logic [LIMB_W:0] res_ext;

  always_comb begin
    if (op_latched == OP_ADD) begin
      sum_ext = {1'b0, base} + {1'b0, acc[LIMB_W-1:0]} + {{LIMB_W{1'b0}}, carry_bit};
    end else begin
      sum_ext = {1'b0, base} - {1'b0, acc[LIMB_W-1:0]} - {{LIMB_W{1'b0}}, carry_bit};
    end
    res_ext = sum_ext;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= base_limb;
      fin  <= last_in || (limb_index == IDX_W'(MAX_LIMBS - 1));
    end
    if (finish) begin
      result_limb <= res_ext[LIMB_W-1:0];
      last_out    <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      limb_index <= '0;
      cnt        <= '0;
      op_latched <= OP_ADD;
      carry_bit  <= 1'b0;
      acc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
        if (limb_index == '0) op_latched <= kind;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (prod_v) acc <= acc + {8'd0, prod};
      if (finish) begin
        out_valid <= 1'b1;
        if (fin) begin
          acc        <= '0;
          carry_bit  <= 1'b0;
          limb_index <= '0;
        end else begin
          acc        <= {{LIMB_W{1'b0}}, acc[ACC_W-1:LIMB_W]};
          carry_bit  <= res_ext[LIMB_W];
          limb_index <= limb_index + 1'b1;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mul_busy)
    else $error("multiplier active while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (cnt <= limb_index))
    else $error("issue count beyond limb index");

  a_accept_run: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (cnt == '0))
    else $error("accepted limb did not start issue");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && (state == ST_IDLE))
    else $error("finish did not load output");

endmodule

`default_nettype wire
